// File: hw/rtl/tltw_pkg.sv
// ----------------------------------------------------------------------------
// tltw_pkg: shared types and constants of the two-level timer wheel
// Sizes of the pool and wheels, status and opcode codes, list kinds,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tltw_pkg;

    // Wheel geometry
    localparam int POOL_SIZE    = 32;
    localparam int FINE_BITS    = 8;
    localparam int COARSE_SLOTS = 64;

    localparam int FINE_SLOTS   = 1 << FINE_BITS;
    localparam int COARSE_BITS  = $clog2(COARSE_SLOTS);
    localparam int IDX_W        = $clog2(POOL_SIZE);
    localparam int PTR_W        = $clog2(POOL_SIZE + 1);
    localparam int CNT_W        = $clog2(POOL_SIZE + 1);
    localparam int SLOT_W       = (FINE_BITS > COARSE_BITS) ? FINE_BITS : COARSE_BITS;
    localparam int SPAN         = FINE_SLOTS * COARSE_SLOTS;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int ID_W       = 32;
    localparam int TAG_W      = 32;
    localparam int OP_W       = 2;
    localparam int ST_W       = 3;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 72;

    typedef logic [PTR_W-1:0] t_ptr;
    localparam t_ptr NIL = '1;

    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_TICK     = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_SCHEDULED = 3'd0,
        ST_FIRED_NOW = 3'd1,
        ST_FULL      = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EXPIRED   = 3'd5,
        ST_TICK_DONE = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        LST_FINE   = 2'd0,
        LST_COARSE = 2'd1,
        LST_OVF    = 2'd2
    } t_list;

    typedef enum logic [1:0] {
        PH_SCHED  = 2'd0,
        PH_COARSE = 2'd1,
        PH_OVF    = 2'd2,
        PH_FINE   = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SC_CHECK,
        S_CN_CHECK,
        S_CN_SCAN,
        S_CN_UNLINK,
        S_TK_ADV,
        S_TK_SEL,
        S_LS_OPEN,
        S_LS_HEAD,
        S_LS_TEST,
        S_LS_NEXT,
        S_LS_STEP,
        S_PL_DELTA,
        S_PL_SLOT,
        S_PL_LINK,
        S_FN_FIRE,
        S_EM_EXP,
        S_EM_FINAL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    alloc;
        logic    scan_start;
        logic    scan_step;
        logic    unlink;
        logic    advance;
        logic    open;
        t_list   open_kind;
        logic    head_take;
        logic    cur_from_x;
        logic    walk_next;
        logic    x_step;
        logic    place_delta;
        logic    place_slot;
        logic    place_link;
        logic    fire;
        logic    emit;
        t_status emit_st;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            past;
        logic            full;
        logic            id_zero;
        logic            hit;
        logic            scan_end;
        logic            fine_wrap;
        logic            coarse_wrap;
        logic            x_valid;
        logic            cur_armed;
        logic            cur_expired;
        logic            cur_notify;
        logic            out_busy;
    } t_dp_sts;

    function automatic logic ptr_ok(input t_ptr p);
        return p < PTR_W'(POOL_SIZE);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tltw_ram.sv
// ----------------------------------------------------------------------------
// tltw_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module tltw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tltw_ctrl.sv
// ----------------------------------------------------------------------------
// tltw_ctrl: sequencer of the timer wheel
// Steps through schedule, cancel and tick; walks slot lists one entry at a
// time and drives the datapath through a command group.
// ----------------------------------------------------------------------------
`default_nettype none

module tltw_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tltw_pkg::t_dp_sts   i_sts,
    output tltw_pkg::t_dp_cmd   o_cmd
);

    tltw_pkg::t_state  r_state, n_state;
    tltw_pkg::t_phase  r_phase, n_phase;
    tltw_pkg::t_status r_est,   n_est;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tltw_pkg::S_IDLE;
            r_phase <= tltw_pkg::PH_SCHED;
            r_est   <= tltw_pkg::ST_TICK_DONE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_est   <= n_est;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_est      = r_est;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tltw_pkg::S_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = tltw_pkg::S_DISPATCH;
                end
            end
            tltw_pkg::S_DISPATCH: begin
                unique case (i_sts.op)
                    tltw_pkg::OP_SCHEDULE: n_state = tltw_pkg::S_SC_CHECK;
                    tltw_pkg::OP_CANCEL:   n_state = tltw_pkg::S_CN_CHECK;
                    tltw_pkg::OP_TICK:     n_state = tltw_pkg::S_TK_ADV;
                    default:               n_state = tltw_pkg::S_IDLE;
                endcase
            end
            tltw_pkg::S_SC_CHECK: begin
                priority if (i_sts.past) begin
                    n_est   = tltw_pkg::ST_FIRED_NOW;
                    n_state = tltw_pkg::S_EM_FINAL;
                end else if (i_sts.full) begin
                    n_est   = tltw_pkg::ST_FULL;
                    n_state = tltw_pkg::S_EM_FINAL;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_phase     = tltw_pkg::PH_SCHED;
                    n_state     = tltw_pkg::S_PL_DELTA;
                end
            end
            tltw_pkg::S_CN_CHECK: begin
                if (i_sts.id_zero) begin
                    n_est   = tltw_pkg::ST_NOT_FOUND;
                    n_state = tltw_pkg::S_EM_FINAL;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = tltw_pkg::S_CN_SCAN;
                end
            end
            tltw_pkg::S_CN_SCAN: begin
                priority if (i_sts.hit) begin
                    n_state = tltw_pkg::S_CN_UNLINK;
                end else if (i_sts.scan_end) begin
                    n_est   = tltw_pkg::ST_NOT_FOUND;
                    n_state = tltw_pkg::S_EM_FINAL;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            tltw_pkg::S_CN_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_est        = tltw_pkg::ST_CANCELLED;
                n_state      = tltw_pkg::S_EM_FINAL;
            end
            tltw_pkg::S_TK_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = tltw_pkg::S_TK_SEL;
            end
            tltw_pkg::S_TK_SEL: begin
                n_phase = i_sts.fine_wrap ? tltw_pkg::PH_COARSE : tltw_pkg::PH_FINE;
                n_state = tltw_pkg::S_LS_OPEN;
            end
            // Detach the head of the list being walked
            tltw_pkg::S_LS_OPEN: begin
                o_cmd.open = 1'b1;
                unique case (r_phase)
                    tltw_pkg::PH_COARSE: o_cmd.open_kind = tltw_pkg::LST_COARSE;
                    tltw_pkg::PH_OVF:    o_cmd.open_kind = tltw_pkg::LST_OVF;
                    default:             o_cmd.open_kind = tltw_pkg::LST_FINE;
                endcase
                n_state = tltw_pkg::S_LS_HEAD;
            end
            tltw_pkg::S_LS_HEAD: begin
                o_cmd.head_take = 1'b1;
                n_state         = tltw_pkg::S_LS_TEST;
            end
            tltw_pkg::S_LS_TEST: begin
                if (i_sts.x_valid) begin
                    o_cmd.cur_from_x = 1'b1;
                    n_state          = tltw_pkg::S_LS_NEXT;
                end else begin
                    unique case (r_phase)
                        tltw_pkg::PH_COARSE: begin
                            n_phase = i_sts.coarse_wrap ? tltw_pkg::PH_OVF
                                                        : tltw_pkg::PH_FINE;
                            n_state = tltw_pkg::S_LS_OPEN;
                        end
                        tltw_pkg::PH_OVF: begin
                            n_phase = tltw_pkg::PH_FINE;
                            n_state = tltw_pkg::S_LS_OPEN;
                        end
                        default: begin
                            n_est   = tltw_pkg::ST_TICK_DONE;
                            n_state = tltw_pkg::S_EM_FINAL;
                        end
                    endcase
                end
            end
            tltw_pkg::S_LS_NEXT: begin
                o_cmd.walk_next = 1'b1;
                if (r_phase == tltw_pkg::PH_FINE) begin
                    priority if (i_sts.cur_expired) begin
                        n_state = tltw_pkg::S_FN_FIRE;
                    end else if (i_sts.cur_armed) begin
                        n_state = tltw_pkg::S_PL_DELTA;
                    end else begin
                        n_state = tltw_pkg::S_LS_STEP;
                    end
                end else begin
                    n_state = tltw_pkg::S_PL_DELTA;
                end
            end
            tltw_pkg::S_LS_STEP: begin
                o_cmd.x_step = 1'b1;
                n_state      = tltw_pkg::S_LS_TEST;
            end
            tltw_pkg::S_PL_DELTA: begin
                o_cmd.place_delta = 1'b1;
                n_state           = tltw_pkg::S_PL_SLOT;
            end
            tltw_pkg::S_PL_SLOT: begin
                o_cmd.place_slot = 1'b1;
                n_state          = tltw_pkg::S_PL_LINK;
            end
            tltw_pkg::S_PL_LINK: begin
                o_cmd.place_link = 1'b1;
                if (r_phase == tltw_pkg::PH_SCHED) begin
                    n_est   = tltw_pkg::ST_SCHEDULED;
                    n_state = tltw_pkg::S_EM_FINAL;
                end else begin
                    n_state = tltw_pkg::S_LS_STEP;
                end
            end
            tltw_pkg::S_FN_FIRE: begin
                o_cmd.fire = 1'b1;
                n_state    = i_sts.cur_notify ? tltw_pkg::S_EM_EXP : tltw_pkg::S_LS_STEP;
            end
            tltw_pkg::S_EM_EXP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = tltw_pkg::ST_EXPIRED;
                    n_state       = tltw_pkg::S_LS_STEP;
                end
            end
            tltw_pkg::S_EM_FINAL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = r_est;
                    n_state       = tltw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tltw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tltw_dp.sv
// ----------------------------------------------------------------------------
// tltw_dp: datapath of the timer wheel
// Entry pool, link arrays, fine and coarse head RAMs with valid bits, the
// overflow head, time and wheel positions, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tltw_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire [tltw_pkg::TIME_W-1:0]         i_cfg_wr_data,
    input  wire [tltw_pkg::OP_W-1:0]           i_opcode,
    input  wire [tltw_pkg::TIME_W-1:0]         i_exp_ms,
    input  wire                                i_notify,
    input  wire [tltw_pkg::TAG_W-1:0]          i_context_tag,
    input  wire [tltw_pkg::ID_W-1:0]           i_cancel_id,
    input  tltw_pkg::t_dp_cmd                  i_cmd,
    output tltw_pkg::t_dp_sts                  o_sts,
    input  wire                                i_m_ready,
    output logic                               o_m_valid,
    output logic [tltw_pkg::ST_W-1:0]          o_status,
    output logic [tltw_pkg::ID_W-1:0]          o_tmr_id,
    output logic [tltw_pkg::TAG_W-1:0]         o_fired_tag,
    output logic [tltw_pkg::CNT_W-1:0]         o_active_timers,
    output logic                               o_last
);

    localparam int PS  = tltw_pkg::POOL_SIZE;
    localparam int FB  = tltw_pkg::FINE_BITS;
    localparam int CB  = tltw_pkg::COARSE_BITS;
    localparam int IW  = tltw_pkg::IDX_W;
    localparam int PW  = tltw_pkg::PTR_W;
    localparam int SW  = tltw_pkg::SLOT_W;
    localparam int TW  = tltw_pkg::TIME_W;

    // Captured input item
    logic [tltw_pkg::OP_W-1:0]  r_op;
    logic [TW-1:0]              r_exp;
    logic                       r_nt;
    logic [tltw_pkg::TAG_W-1:0] r_tag;
    logic [tltw_pkg::ID_W-1:0]  r_cid;

    // Wheel control state
    logic [TW-1:0]               r_now;
    logic [FB-1:0]               r_fpos;
    logic [CB-1:0]               r_cpos;
    logic [tltw_pkg::ID_W-1:0]   r_idc;
    logic [tltw_pkg::CNT_W-1:0]  r_cnt;
    logic [PS-1:0]               r_armed;
    logic [tltw_pkg::FINE_SLOTS-1:0]   r_fvld;
    logic [tltw_pkg::COARSE_SLOTS-1:0] r_cvld;
    tltw_pkg::t_ptr              r_ovf;

    // Entry payload
    logic [TW-1:0]               r_expiry [PS];
    logic                        r_notify [PS];
    logic [tltw_pkg::TAG_W-1:0]  r_etag   [PS];
    logic [tltw_pkg::ID_W-1:0]   r_ident  [PS];
    tltw_pkg::t_ptr              r_fwd    [PS];
    tltw_pkg::t_ptr              r_bwd    [PS];
    tltw_pkg::t_list             r_lkind  [PS];
    logic [SW-1:0]               r_lslot  [PS];

    // Walk and placement registers
    logic [IW-1:0]               r_cur;
    tltw_pkg::t_ptr              r_x;
    tltw_pkg::t_ptr              r_nx;
    logic [TW-1:0]               r_delta;
    tltw_pkg::t_list             r_tkind;
    logic [SW-1:0]               r_tslot;
    tltw_pkg::t_list             r_hkind;
    logic                        r_fvq;
    logic                        r_cvq;
    tltw_pkg::t_ptr              r_ovq;
    logic [tltw_pkg::ID_W-1:0]   r_new_id;

    // Result register
    logic                        r_mv;
    logic [tltw_pkg::ST_W-1:0]   r_ost;
    logic [tltw_pkg::ID_W-1:0]   r_oid;
    logic [tltw_pkg::TAG_W-1:0]  r_otag;
    logic [tltw_pkg::CNT_W-1:0]  r_oact;
    logic                        r_olast;

    logic                        free_found;
    logic [IW-1:0]               free_idx;
    tltw_pkg::t_ptr              hd;
    tltw_pkg::t_ptr              cur_ptr;
    tltw_pkg::t_ptr              un_p;
    tltw_pkg::t_ptr              un_n;
    tltw_pkg::t_list             t_kind_c;
    logic [SW-1:0]               t_slot_c;
    logic [FB-1:0]               fsum;
    logic [CB:0]                 csum;
    logic [CB:0]                 cmod;
    logic [CB-1:0]               cnext;
    logic                        hw_en;
    tltw_pkg::t_list             hw_kind;
    logic [SW-1:0]               hw_slot;
    tltw_pkg::t_ptr              hw_ptr;
    logic [FB-1:0]               f_raddr;
    logic [CB-1:0]               c_raddr;
    tltw_pkg::t_ptr              f_rdata;
    tltw_pkg::t_ptr              c_rdata;
    logic                        f_we;
    logic                        c_we;
    logic [tltw_pkg::ID_W-1:0]   idc_inc;
    logic                        out_busy;

    assign cur_ptr  = PW'(r_cur);
    assign un_p     = r_bwd[r_cur];
    assign un_n     = r_fwd[r_cur];
    assign out_busy = r_mv && !i_m_ready;
    assign idc_inc  = r_idc + 1'b1;

    // Lowest free entry
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PS - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Head read result
    always_comb begin
        unique case (r_hkind)
            tltw_pkg::LST_FINE:   hd = r_fvq ? f_rdata : tltw_pkg::NIL;
            tltw_pkg::LST_COARSE: hd = r_cvq ? c_rdata : tltw_pkg::NIL;
            default:              hd = r_ovq;
        endcase
    end

    // Placement target from the registered delta
    always_comb begin
        fsum = r_fpos + r_delta[FB-1:0];
        csum = {1'b0, r_cpos} + {1'b0, r_delta[FB +: CB]};
        cmod = (csum >= (CB+1)'(tltw_pkg::COARSE_SLOTS))
             ? csum - (CB+1)'(tltw_pkg::COARSE_SLOTS) : csum;
        if (r_delta < TW'(tltw_pkg::FINE_SLOTS)) begin
            t_kind_c = tltw_pkg::LST_FINE;
            t_slot_c = SW'(fsum);
        end else if (r_delta < TW'(tltw_pkg::SPAN)) begin
            t_kind_c = tltw_pkg::LST_COARSE;
            t_slot_c = SW'(cmod[CB-1:0]);
        end else begin
            t_kind_c = tltw_pkg::LST_OVF;
            t_slot_c = '0;
        end
    end

    assign cnext = (r_cpos == CB'(tltw_pkg::COARSE_SLOTS - 1)) ? '0 : r_cpos + 1'b1;

    // Head write: new head on placement, successor on unlink of a head
    always_comb begin
        hw_en   = 1'b0;
        hw_kind = r_tkind;
        hw_slot = r_tslot;
        hw_ptr  = cur_ptr;
        if (i_cmd.place_link) begin
            hw_en = 1'b1;
        end else if (i_cmd.unlink && !tltw_pkg::ptr_ok(un_p)) begin
            hw_en   = 1'b1;
            hw_kind = r_lkind[r_cur];
            hw_slot = r_lslot[r_cur];
            hw_ptr  = un_n;
        end
    end

    assign f_we    = hw_en && (hw_kind == tltw_pkg::LST_FINE);
    assign c_we    = hw_en && (hw_kind == tltw_pkg::LST_COARSE);
    assign f_raddr = i_cmd.open ? r_fpos : t_slot_c[FB-1:0];
    assign c_raddr = i_cmd.open ? r_cpos : t_slot_c[CB-1:0];

    tltw_ram #(.WIDTH(PW), .DEPTH(tltw_pkg::FINE_SLOTS)) u_fine_heads (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (hw_slot[FB-1:0]),
        .i_wdata (hw_ptr),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    tltw_ram #(.WIDTH(PW), .DEPTH(tltw_pkg::COARSE_SLOTS)) u_coarse_heads (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (hw_slot[CB-1:0]),
        .i_wdata (hw_ptr),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // Control state with reset and re-init on a start time write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_now   <= i_rst_n ? i_cfg_wr_data : '0;
            r_fpos  <= i_rst_n ? i_cfg_wr_data[FB-1:0] : '0;
            r_cpos  <= i_rst_n ? i_cfg_wr_data[FB +: CB] : '0;
            r_idc   <= tltw_pkg::ID_W'(1);
            r_cnt   <= '0;
            r_armed <= '0;
            r_fvld  <= '0;
            r_cvld  <= '0;
            r_ovf   <= tltw_pkg::NIL;
        end else begin
            if (i_cmd.advance) begin
                r_now  <= r_now + 1'b1;
                r_fpos <= r_fpos + 1'b1;
                if (&r_fpos) begin
                    r_cpos <= cnext;
                end
            end
            if (i_cmd.alloc) begin
                r_armed[free_idx] <= 1'b1;
                r_cnt             <= r_cnt + 1'b1;
                r_idc             <= (idc_inc == '0) ? tltw_pkg::ID_W'(1) : idc_inc;
            end
            if (i_cmd.unlink || i_cmd.fire) begin
                r_armed[r_cur] <= 1'b0;
                r_cnt          <= r_cnt - 1'b1;
            end
            // Detaching a list clears its head
            if (i_cmd.open) begin
                unique case (i_cmd.open_kind)
                    tltw_pkg::LST_FINE:   r_fvld[r_fpos] <= 1'b0;
                    tltw_pkg::LST_COARSE: r_cvld[r_cpos] <= 1'b0;
                    default:              r_ovf          <= tltw_pkg::NIL;
                endcase
            end
            if (hw_en) begin
                unique case (hw_kind)
                    tltw_pkg::LST_FINE:   r_fvld[hw_slot[FB-1:0]] <= tltw_pkg::ptr_ok(hw_ptr);
                    tltw_pkg::LST_COARSE: r_cvld[hw_slot[CB-1:0]] <= tltw_pkg::ptr_ok(hw_ptr);
                    default:              r_ovf <= hw_ptr;
                endcase
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_exp <= i_exp_ms;
            r_nt  <= i_notify;
            r_tag <= i_context_tag;
            r_cid <= i_cancel_id;
        end
        if (i_cmd.alloc) begin
            r_expiry[free_idx] <= r_exp;
            r_notify[free_idx] <= r_nt;
            r_etag[free_idx]   <= r_tag;
            r_ident[free_idx]  <= r_idc;
            r_new_id           <= r_idc;
            r_cur              <= free_idx;
        end
        if (i_cmd.scan_start) begin
            r_cur <= '0;
        end
        if (i_cmd.scan_step) begin
            r_cur <= r_cur + 1'b1;
        end
        // Splice neighbors around the cancelled entry
        if (i_cmd.unlink) begin
            if (tltw_pkg::ptr_ok(un_p)) begin
                r_fwd[un_p[IW-1:0]] <= un_n;
            end
            if (tltw_pkg::ptr_ok(un_n)) begin
                r_bwd[un_n[IW-1:0]] <= un_p;
            end
        end
        if (i_cmd.open || i_cmd.place_slot) begin
            r_hkind <= i_cmd.open ? i_cmd.open_kind : t_kind_c;
            r_ovq   <= r_ovf;
        end
        r_fvq <= r_fvld[f_raddr];
        r_cvq <= r_cvld[c_raddr];
        if (i_cmd.head_take) begin
            r_x <= hd;
        end
        if (i_cmd.cur_from_x) begin
            r_cur <= r_x[IW-1:0];
        end
        if (i_cmd.walk_next) begin
            r_nx <= r_fwd[r_cur];
        end
        if (i_cmd.x_step) begin
            r_x <= r_nx;
        end
        if (i_cmd.place_delta) begin
            r_delta <= r_expiry[r_cur] - r_now;
        end
        if (i_cmd.place_slot) begin
            r_tkind <= t_kind_c;
            r_tslot <= t_slot_c;
        end
        // Push at the head of the target list
        if (i_cmd.place_link) begin
            r_fwd[r_cur]   <= hd;
            r_bwd[r_cur]   <= tltw_pkg::NIL;
            r_lkind[r_cur] <= r_tkind;
            r_lslot[r_cur] <= r_tslot;
            if (tltw_pkg::ptr_ok(hd)) begin
                r_bwd[hd[IW-1:0]] <= cur_ptr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (i_cmd.emit) begin
            r_mv <= 1'b1;
        end else if (i_m_ready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ost   <= i_cmd.emit_st;
            r_oact  <= r_cnt;
            r_olast <= (i_cmd.emit_st != tltw_pkg::ST_EXPIRED);
            unique case (i_cmd.emit_st)
                tltw_pkg::ST_SCHEDULED: begin
                    r_oid  <= r_new_id;
                    r_otag <= '0;
                end
                tltw_pkg::ST_FIRED_NOW: begin
                    r_oid  <= '0;
                    r_otag <= r_nt ? r_tag : '0;
                end
                tltw_pkg::ST_EXPIRED: begin
                    r_oid  <= r_ident[r_cur];
                    r_otag <= r_etag[r_cur];
                end
                default: begin
                    r_oid  <= '0;
                    r_otag <= '0;
                end
            endcase
        end
    end

    assign o_m_valid       = r_mv;
    assign o_status        = r_ost;
    assign o_tmr_id        = r_oid;
    assign o_fired_tag     = r_otag;
    assign o_active_timers = r_oact;
    assign o_last          = r_olast;

    // Status to the controller
    always_comb begin
        o_sts             = '0;
        o_sts.op          = r_op;
        o_sts.past        = (r_exp <= r_now);
        o_sts.full        = !free_found;
        o_sts.id_zero     = (r_cid == '0);
        o_sts.hit         = r_armed[r_cur] && (r_ident[r_cur] == r_cid);
        o_sts.scan_end    = (r_cur == IW'(PS - 1));
        o_sts.fine_wrap   = (r_fpos == '0);
        o_sts.coarse_wrap = (r_cpos == '0);
        o_sts.x_valid     = tltw_pkg::ptr_ok(r_x);
        o_sts.cur_armed   = r_armed[r_cur];
        o_sts.cur_expired = r_armed[r_cur] && (r_expiry[r_cur] <= r_now);
        o_sts.cur_notify  = r_notify[r_cur];
        o_sts.out_busy    = out_busy;
    end

    // Checks
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == tltw_pkg::CNT_W'($countones(r_armed)))
        else $error("armed count out of step with armed bits");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !out_busy)
        else $error("result written over an untaken result");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !(&r_armed))
        else $error("allocation with a full pool");

    a_unlink_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.unlink && !i_cfg_wr_en) |=> !r_armed[$past(r_cur)])
        else $error("cancelled entry still armed");

endmodule

`default_nettype wire

// File: hw/rtl/two_level_timer_wheel.sv
// ----------------------------------------------------------------------------
// two_level_timer_wheel: hierarchical timing wheel over a 32-entry pool
// Schedule, cancel and one-ms tick over a fine wheel, a coarse wheel and an
// overflow list; a tick reports expired notify timers, then a done result.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser opcode; tdata item fields
//   m_axis    out  m_axis_tvalid/tready       tuser status; tdata; tlast
//   cfg       in   i_cfg_wr_en                i_cfg_wr_data start time
//
// Cancel scans the pool for the entry, one entry per cycle.
// A tick may open the coarse list and then the overflow list before the fine
// list; entries are re-placed or fired, and the walk is one entry at a time.
// Reset (synchronous, active low) and a start time write clear the wheel at
// once. Input is taken only when idle; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_timer_wheel (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [tltw_pkg::TIME_W-1:0]           i_cfg_wr_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [47:0] expiry, [48] notify, [80:49] context_tag, [112:81] cancel_id
    input  wire [tltw_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [1:0] opcode
    input  wire [tltw_pkg::OP_W-1:0]             s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [31:0] timer ident, [63:32] fired_tag, [69:64] active_timers
    output logic [tltw_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [2:0] status
    output logic [tltw_pkg::ST_W-1:0]            m_axis_tuser,
    output logic                                 m_axis_tlast
);

    tltw_pkg::t_dp_cmd            cmd;
    tltw_pkg::t_dp_sts            sts;
    logic [tltw_pkg::ID_W-1:0]    tmr_id;
    logic [tltw_pkg::TAG_W-1:0]   fired_tag;
    logic [tltw_pkg::CNT_W-1:0]   active_timers;

    tltw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tltw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (s_axis_tuser),
        .i_exp_ms        (s_axis_tdata[47:0]),
        .i_notify        (s_axis_tdata[48]),
        .i_context_tag   (s_axis_tdata[80:49]),
        .i_cancel_id     (s_axis_tdata[112:81]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_m_ready       (m_axis_tready),
        .o_m_valid       (m_axis_tvalid),
        .o_status        (m_axis_tuser),
        .o_tmr_id        (tmr_id),
        .o_fired_tag     (fired_tag),
        .o_active_timers (active_timers),
        .o_last          (m_axis_tlast)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_axis_tdata = {2'b00, active_timers, fired_tag, tmr_id};

endmodule

`default_nettype wire

// File: dv/two_level_timer_wheel_tb.sv
// ----------------------------------------------------------------------------
// two_level_timer_wheel_tb: self-checking bench of the two-level timer wheel
// Drives schedule, cancel and tick transfers under random bursts and output
// stalls, predicts every result with an in-bench model of the wheel, and
// compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_timer_wheel_tb;

    localparam int POOL_SIZE    = tltw_pkg::POOL_SIZE;
    localparam int FINE_SLOTS   = tltw_pkg::FINE_SLOTS;
    localparam int COARSE_SLOTS = tltw_pkg::COARSE_SLOTS;
    localparam int SPAN         = tltw_pkg::SPAN;
    localparam int TIME_W       = tltw_pkg::TIME_W;
    localparam int OP_W         = tltw_pkg::OP_W;
    localparam int ST_W         = tltw_pkg::ST_W;
    localparam int IN_DATA_W    = tltw_pkg::IN_DATA_W;
    localparam int OUT_DATA_W   = tltw_pkg::OUT_DATA_W;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         NULL_IDX  = 63;
    localparam int         OVF_HEAD  = FINE_SLOTS + COARSE_SLOTS;
    localparam int         CYCLE_CAP = 600000;

    typedef struct {
        tltw_pkg::t_status st;
        logic [31:0]       id;
        logic [31:0]       tag;
        logic [5:0]        act;
        logic              last;
    } t_result;

    typedef struct {
        logic [1:0]        op;
        logic [47:0]       exp;
        logic              ntf;
        logic [31:0]       tag;
        logic [31:0]       cid;
        bit                typed;
        tltw_pkg::t_status st;
        logic [31:0]       id;
        logic [31:0]       ftag;
        logic [5:0]        act;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [TIME_W-1:0]     i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [47:0] exp, [48] notify, [80:49] tag, [112:81] id
    logic [OP_W-1:0]       s_axis_tuser = '0;   // [1:0] opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [31:0] id, [63:32] tag, [69:64] active
    logic [ST_W-1:0]       m_axis_tuser;        // [2:0] status
    logic                  m_axis_tlast;

    two_level_timer_wheel u_top (.*);

    always #2 i_clk = ~i_clk;

    // Wheel model state
    logic [47:0] tm_exp  [POOL_SIZE];
    logic [31:0] tm_id   [POOL_SIZE];
    bit          tm_arm  [POOL_SIZE];
    bit          tm_ntf  [POOL_SIZE];
    logic [31:0] tm_tag  [POOL_SIZE];
    int          lnk_nxt [POOL_SIZE];
    int          lnk_prv [POOL_SIZE];
    int          heads   [OVF_HEAD + 1];
    logic [47:0] now_ms;
    logic [7:0]  fpos;
    logic [5:0]  cpos;
    logic [31:0] id_next;
    logic [5:0]  n_armed;

    t_result     expected_q[$];
    logic [31:0] live_ids[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_expired = 0;
    int          n_cascades = 0;
    int          cycles = 0;
    int          burst_left = 0;

    function automatic void wheel_clear(input logic [47:0] start);
        for (int i = 0; i < POOL_SIZE; i++) begin
            tm_id[i] = '0; tm_arm[i] = 0; tm_ntf[i] = 0; tm_tag[i] = '0; tm_exp[i] = '0;
            lnk_nxt[i] = NULL_IDX; lnk_prv[i] = NULL_IDX;
        end
        foreach (heads[i]) heads[i] = NULL_IDX;
        now_ms = start;
        fpos = start[7:0];
        cpos = start[13:8];
        id_next = 32'd1;
        n_armed = '0;
        live_ids.delete();
    endfunction

    function automatic void push_list(input int h, input int e);
        lnk_nxt[e] = heads[h];
        lnk_prv[e] = NULL_IDX;
        if (heads[h] < POOL_SIZE) lnk_prv[heads[h]] = e;
        heads[h] = e;
    endfunction

    function automatic void place_timer(input int e);
        logic [47:0] d;
        logic [5:0]  cs;
        d = tm_exp[e] - now_ms;
        cs = cpos + d[13:8];
        if (d < 48'(FINE_SLOTS)) push_list(int'(8'(fpos + d[7:0])), e);
        else if (d < 48'(SPAN)) push_list(FINE_SLOTS + int'(cs), e);
        else push_list(OVF_HEAD, e);
    endfunction

    function automatic void unlink_timer(input int e);
        int p;
        int n;
        p = lnk_prv[e];
        n = lnk_nxt[e];
        if (p < POOL_SIZE) lnk_nxt[p] = n;
        if (n < POOL_SIZE) lnk_prv[n] = p;
        foreach (heads[i]) if (heads[i] == e) heads[i] = n;
        lnk_nxt[e] = NULL_IDX;
        lnk_prv[e] = NULL_IDX;
    endfunction

    function automatic void reflow_list(input int h);
        int x;
        int nx;
        x = heads[h];
        heads[h] = NULL_IDX;
        while (x < POOL_SIZE) begin
            nx = lnk_nxt[x];
            lnk_nxt[x] = NULL_IDX;
            lnk_prv[x] = NULL_IDX;
            place_timer(x);
            x = nx;
        end
    endfunction

    function automatic void add_result(input tltw_pkg::t_status st, input logic [31:0] id,
                                       input logic [31:0] tag, input logic last);
        t_result r;
        r.st = st; r.id = id; r.tag = tag; r.act = n_armed; r.last = last;
        expected_q.push_back(r);
    endfunction

    // Applies one accepted item to the wheel model and queues its results
    function automatic void wheel_apply(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        logic [47:0] ex;
        logic [31:0] tag;
        logic [31:0] cid;
        logic        ntf;
        int          e;
        int          x;
        int          nx;
        ex = d[47:0]; ntf = d[48]; tag = d[80:49]; cid = d[112:81];
        case (op)
            tltw_pkg::OP_SCHEDULE: begin
                if (ex <= now_ms) begin
                    add_result(tltw_pkg::ST_FIRED_NOW, '0, ntf ? tag : '0, 1'b1);
                    return;
                end
                e = 0;
                while (e < POOL_SIZE && tm_arm[e]) e++;
                if (e >= POOL_SIZE) begin
                    add_result(tltw_pkg::ST_FULL, '0, '0, 1'b1);
                    return;
                end
                tm_exp[e] = ex; tm_ntf[e] = ntf; tm_tag[e] = tag; tm_id[e] = id_next;
                live_ids.push_back(id_next);
                if (live_ids.size() > 64) void'(live_ids.pop_front());
                id_next++;
                if (id_next == 0) id_next = 32'd1;
                tm_arm[e] = 1;
                place_timer(e);
                n_armed++;
                add_result(tltw_pkg::ST_SCHEDULED, tm_id[e], '0, 1'b1);
            end
            tltw_pkg::OP_CANCEL: begin
                e = POOL_SIZE;
                if (cid != 0) begin
                    e = 0;
                    while (e < POOL_SIZE && !(tm_arm[e] && tm_id[e] == cid)) e++;
                end
                if (e >= POOL_SIZE) begin
                    add_result(tltw_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                    return;
                end
                unlink_timer(e);
                tm_arm[e] = 0; tm_id[e] = '0;
                n_armed--;
                add_result(tltw_pkg::ST_CANCELLED, '0, '0, 1'b1);
            end
            tltw_pkg::OP_TICK: begin
                now_ms++;
                fpos++;
                if (fpos == 0) begin
                    cpos++;
                    n_cascades++;
                    reflow_list(FINE_SLOTS + int'(cpos));
                    if (cpos == 0) reflow_list(OVF_HEAD);
                end
                x = heads[fpos];
                heads[fpos] = NULL_IDX;
                while (x < POOL_SIZE) begin
                    nx = lnk_nxt[x];
                    lnk_nxt[x] = NULL_IDX;
                    lnk_prv[x] = NULL_IDX;
                    if (tm_arm[x] && tm_exp[x] <= now_ms) begin
                        tm_arm[x] = 0;
                        n_armed--;
                        if (tm_ntf[x]) begin
                            add_result(tltw_pkg::ST_EXPIRED, tm_id[x], tm_tag[x], 1'b0);
                        end
                        tm_id[x] = '0;
                    end else if (tm_arm[x]) begin
                        place_timer(x);
                    end
                    x = nx;
                end
                add_result(tltw_pkg::ST_TICK_DONE, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(input logic [47:0] ex, input logic ntf,
                                                      input logic [31:0] tag,
                                                      input logic [31:0] cid);
        return {7'd0, cid, tag, ntf, ex};
    endfunction

    // One input transfer, with burst and gap shaping on the sender side
    task automatic send_item(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = d;
        do @(posedge i_clk); while (!s_axis_tready);
        wheel_apply(op, d);
        n_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid = 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [47:0] start);
        drain_and_settle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = start;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        wheel_clear(start);
    endtask

    task automatic schedule_random();
        logic [47:0] ex;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 50)      ex = now_ms + 48'($urandom_range(1, 20));
        else if (k < 70) ex = now_ms + 48'($urandom_range(21, 600));
        else if (k < 80) ex = now_ms + 48'($urandom_range(600, 40000));
        else if (k < 90) ex = now_ms - 48'($urandom_range(0, 5));
        else             ex = {16'($urandom), 32'($urandom)};
        send_item(tltw_pkg::OP_SCHEDULE, pack_item(ex, 1'($urandom), $urandom, $urandom));
    endtask

    task automatic run_random(input int count);
        int k;
        int stop;
        stop = n_items + count;
        while (n_items < stop) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                send_item(tltw_pkg::OP_TICK,
                          pack_item({16'($urandom), 32'($urandom)}, 1'($urandom),
                                    $urandom, $urandom));
            end else if (k < 70) begin
                schedule_random();
            end else if (k < 84 && live_ids.size() != 0) begin
                send_item(tltw_pkg::OP_CANCEL, pack_item('0, 1'b0, $urandom,
                          live_ids[$urandom_range(0, live_ids.size() - 1)]));
            end else if (k < 90) begin
                send_item(tltw_pkg::OP_CANCEL, pack_item('0, 1'($urandom), $urandom,
                          ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom));
            end else if (k < 92) begin
                send_item(OP_UNUSED, pack_item('0, 1'b0, $urandom, $urandom));
            end else if (k < 95) begin
                // fill the pool and bump into the full case
                while (n_armed < POOL_SIZE) schedule_random();
                send_item(tltw_pkg::OP_SCHEDULE, pack_item(now_ms + 48'd5, 1'b1, $urandom, '0));
            end else begin
                schedule_random();
            end
        end
    endtask

    // Receiver stall pattern
    int rx_mode = 0;
    always @(negedge i_clk) begin
        if (cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom);
            2: m_axis_tready = (cycles % 5) != 0;
            default: m_axis_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d id %0h tag %0h act %0d last %0b",
                         $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                         m_axis_tdata[69:64], m_axis_tlast);
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.st == tltw_pkg::ST_EXPIRED) n_expired++;
                if (m_axis_tuser != exp_r.st || m_axis_tdata[31:0] != exp_r.id ||
                    m_axis_tdata[63:32] != exp_r.tag || m_axis_tdata[69:64] != exp_r.act ||
                    m_axis_tlast != exp_r.last) begin
                    errors++;
                    $display("%0t: mismatch: expected st %0d id %0h tag %0h act %0d last %0b",
                             $time, exp_r.st, exp_r.id, exp_r.tag, exp_r.act, exp_r.last);
                    $display("%0t:           actual   st %0d id %0h tag %0h act %0d last %0b",
                             $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                             m_axis_tdata[69:64], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    t_row dir_rows[14];

    initial begin
        // after reset, start time zero
        dir_rows[0]  = '{tltw_pkg::OP_CANCEL,   48'd0, 1'b0, 32'd0, 32'd0, 1,
                         tltw_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 6'd0};
        dir_rows[1]  = '{tltw_pkg::OP_SCHEDULE, 48'd0, 1'b1, 32'hFFFF_FFFF, 32'd0, 1,
                         tltw_pkg::ST_FIRED_NOW, 32'd0, 32'hFFFF_FFFF, 6'd0};
        dir_rows[2]  = '{tltw_pkg::OP_SCHEDULE, 48'd0, 1'b0, 32'h1234_5678, 32'd0, 1,
                         tltw_pkg::ST_FIRED_NOW, 32'd0, 32'd0, 6'd0};
        dir_rows[3]  = '{tltw_pkg::OP_SCHEDULE, 48'd1, 1'b1, 32'h0000_AAAA, 32'd0, 1,
                         tltw_pkg::ST_SCHEDULED, 32'd1, 32'd0, 6'd1};
        dir_rows[4]  = '{tltw_pkg::OP_SCHEDULE, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h5555_5555,
                         32'd0, 1, tltw_pkg::ST_SCHEDULED, 32'd2, 32'd0, 6'd2};
        dir_rows[5]  = '{tltw_pkg::OP_SCHEDULE, 48'd256, 1'b0, 32'h0000_0001, 32'd0, 1,
                         tltw_pkg::ST_SCHEDULED, 32'd3, 32'd0, 6'd3};
        dir_rows[6]  = '{tltw_pkg::OP_SCHEDULE, 48'd255, 1'b1, 32'h8000_0000, 32'd0, 1,
                         tltw_pkg::ST_SCHEDULED, 32'd4, 32'd0, 6'd4};
        dir_rows[7]  = '{tltw_pkg::OP_TICK,     48'd0, 1'b0, 32'd0, 32'd0, 0,
                         tltw_pkg::ST_TICK_DONE, 32'd0, 32'd0, 6'd0};
        dir_rows[8]  = '{tltw_pkg::OP_CANCEL,   48'd0, 1'b0, 32'd0, 32'd2, 1,
                         tltw_pkg::ST_CANCELLED, 32'd0, 32'd0, 6'd2};
        dir_rows[9]  = '{tltw_pkg::OP_CANCEL,   48'd0, 1'b0, 32'd0, 32'd2, 1,
                         tltw_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 6'd2};
        dir_rows[10] = '{tltw_pkg::OP_CANCEL,   48'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1,
                         tltw_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 6'd2};
        dir_rows[11] = '{OP_UNUSED,             48'd0, 1'b0, 32'd0, 32'd0, 0,
                         tltw_pkg::ST_TICK_DONE, 32'd0, 32'd0, 6'd0};
        // expiry equal to current time counts as passed
        dir_rows[12] = '{tltw_pkg::OP_SCHEDULE, 48'd1, 1'b1, 32'h0F0F_0F0F, 32'd0, 1,
                         tltw_pkg::ST_FIRED_NOW, 32'd0, 32'h0F0F_0F0F, 6'd2};
        dir_rows[13] = '{tltw_pkg::OP_TICK,     48'd0, 1'b0, 32'd0, 32'd0, 0,
                         tltw_pkg::ST_TICK_DONE, 32'd0, 32'd0, 6'd0};

        wheel_clear('0);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            t_result r;
            send_item(dir_rows[i].op, pack_item(dir_rows[i].exp, dir_rows[i].ntf,
                                                dir_rows[i].tag, dir_rows[i].cid));
            if (dir_rows[i].typed) begin
                void'(expected_q.pop_back());
                r.st = dir_rows[i].st; r.id = dir_rows[i].id; r.tag = dir_rows[i].ftag;
                r.act = dir_rows[i].act; r.last = 1'b1;
                expected_q.push_back(r);
            end
        end
        run_random(50);

        // near the end of a coarse turn: fine and overflow cascades come soon
        write_start(48'h0000_1234_3FF0);
        run_random(75);
        // top of the time range, so the clock wraps
        write_start(48'hFFFF_FFFF_FFE0);
        run_random(70);
        write_start(48'h0);
        run_random(60);

        drain_and_settle();
        $display("Ran %0d items, checked %0d results (%0d expirations, %0d fine wraps).",
                 n_items, n_results, n_expired, n_cascades);
        $display("Start times 0, mid-range and top of range; pool-full and cancel cases.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: two_level_timer_wheel.f
hw/rtl/tltw_pkg.sv
hw/rtl/tltw_ram.sv
hw/rtl/tltw_ctrl.sv
hw/rtl/tltw_dp.sv
hw/rtl/two_level_timer_wheel.sv
dv/two_level_timer_wheel_tb.sv
